// ===== hw/rtl/sle_pkg.sv =====
// Shared constants and types for the sorted list engine.
`default_nettype none
package sle_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int POS_W    = 8;
  localparam int ACT_W    = 3;
  localparam int ECNT_W   = 9;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT       = 3'd0,
    ACT_REMOVE_VALUE = 3'd1,
    ACT_REMOVE_POS   = 3'd2,
    ACT_READ         = 3'd3,
    ACT_FIND         = 3'd4,
    ACT_CLEAR        = 3'd5
  } act_t;

  typedef enum logic [1:0] {
    OP_HOLD      = 2'd0,
    OP_INSERT    = 2'd1,
    OP_DEL_VALUE = 2'd2,
    OP_DEL_POS   = 2'd3
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        pos_idx;
  } ctrl_t;

  typedef struct packed {
    logic [CNT_W-1:0]        k;
    logic                    found;
    logic signed [VAL_W-1:0] rd_val;
  } stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sle_req_if.sv =====
// Request channel: action, value and position with valid/ready.
`default_nettype none
interface sle_req_if;
  logic                                    valid;
  logic                                    ready;
  logic [sle_pkg::ACT_W-1:0]               action;
  logic signed [sle_pkg::VAL_W-1:0]        value;
  logic [sle_pkg::POS_W-1:0]               position;

  modport source (output valid, action, value, position, input ready);
  modport sink   (input valid, action, value, position, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sle_rsp_if.sv =====
// Response channel: ok flag, entry value, found position and count with valid/ready.
`default_nettype none
interface sle_rsp_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    ok;
  logic signed [sle_pkg::VAL_W-1:0]        entry_value;
  logic [sle_pkg::POS_W-1:0]               found_position;
  logic [sle_pkg::ECNT_W-1:0]              entry_count;

  modport source (output valid, ok, entry_value, found_position, entry_count, input ready);
  modport sink   (input valid, ok, entry_value, found_position, entry_count, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sle_cell.sv =====
// One storage cell of the sorted chain: compare against the request and shift.
`default_nettype none
module sle_cell (
  input  wire logic                              clk,
  input  wire sle_pkg::op_t                      op,
  input  wire logic signed [sle_pkg::VAL_W-1:0]  value,
  input  wire logic [sle_pkg::IDX_W-1:0]         del_idx,
  input  wire logic [sle_pkg::CNT_W-1:0]         count,
  input  wire logic [sle_pkg::IDX_W-1:0]         idx,
  input  wire logic                              left_less,
  input  wire logic signed [sle_pkg::VAL_W-1:0]  left_val,
  input  wire logic signed [sle_pkg::VAL_W-1:0]  right_val,
  output logic                                   less,
  output logic                                   eq,
  output logic signed [sle_pkg::VAL_W-1:0]       val
);
  import sle_pkg::*;

  logic                    in_use;
  logic signed [VAL_W-1:0] val_next;

  assign in_use = CNT_W'(idx) < count;
  assign less   = in_use && (val < value);
  assign eq     = in_use && (val == value);

  always_comb begin
    val_next = val;
    case (op)
      OP_INSERT: begin
        if (!less) begin
          val_next = left_less ? value : left_val;
        end
      end
      OP_DEL_VALUE, OP_DEL_POS: begin
        if (idx >= del_idx) begin
          val_next = right_val;
        end
      end
      default: val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sle_chain.sv =====
// Row of cells with the insertion index count, match detect and read select.
`default_nettype none
module sle_chain (
  input  wire logic                        clk,
  input  wire sle_pkg::ctrl_t              ctrl,
  input  wire logic [sle_pkg::CNT_W-1:0]   count,
  input  wire logic [sle_pkg::IDX_W-1:0]   rd_idx,
  output sle_pkg::stat_t                   stat
);
  import sle_pkg::*;

  logic signed [VAL_W-1:0] vals [CAPACITY];
  logic [CAPACITY-1:0]     less_vec;
  logic [CAPACITY-1:0]     eq_vec;
  logic [CNT_W-1:0]        k;
  logic [IDX_W-1:0]        del_idx;

  always_comb begin
    k = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      k = k + CNT_W'(less_vec[i]);
    end
  end

  assign del_idx = (ctrl.op == OP_DEL_VALUE) ? k[IDX_W-1:0] : ctrl.pos_idx;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    left_less;
    logic signed [VAL_W-1:0] left_val;
    logic signed [VAL_W-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_less = 1'b1;
      assign left_val  = ctrl.value;
    end else begin : g_mid
      assign left_less = less_vec[i-1];
      assign left_val  = vals[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val = vals[i];
    end else begin : g_inner
      assign right_val = vals[i+1];
    end

    sle_cell u_cell (
      .clk       (clk),
      .op        (ctrl.op),
      .value     (ctrl.value),
      .del_idx   (del_idx),
      .count     (count),
      .idx       (IDX_W'(i)),
      .left_less (left_less),
      .left_val  (left_val),
      .right_val (right_val),
      .less      (less_vec[i]),
      .eq        (eq_vec[i]),
      .val       (vals[i])
    );
  end

  assign stat.k      = k;
  assign stat.found  = |eq_vec;
  assign stat.rd_val = vals[rd_idx];

endmodule
`default_nettype wire

// ===== hw/rtl/sorted_list_engine_top.sv =====
// Top level of the sorted list engine: request decode, count and response register.
`default_nettype none
// Sorted list of up to CAPACITY signed 32-bit values held in a row of cells.
// Every cell compares its entry with the request at once and shifts one place
// towards its neighbour on insert or removal, so the whole row is updated at once:
// one request is taken every cycle while no response waits to be taken, and its
// response appears in the registered output in the cycle after. The request side
// stalls only while a response waits to be taken. Entries read beyond the current
// count are never reported; no clearing pass follows reset.
module sorted_list_engine_top (
  input  wire logic  clk,
  input  wire logic  rst,
  sle_req_if.sink    req,
  sle_rsp_if.source  rsp
);
  import sle_pkg::*;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              accept;
  ctrl_t             ctrl;
  stat_t             stat;
  logic [POS_W-1:0]  pos_m1;
  logic              pos_ok;
  logic              ok_next;
  logic signed [VAL_W-1:0] rd_next;
  logic [POS_W-1:0]  fp_next;
  logic [ECNT_W-1:0] fp_sum;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign pos_m1 = req.position - POS_W'(1);
  assign pos_ok = (req.position != '0) && (ECNT_W'(req.position) <= ECNT_W'(count));
  assign fp_sum = ECNT_W'(stat.k) + ECNT_W'(1);

  sle_chain u_chain (
    .clk    (clk),
    .ctrl   (ctrl),
    .count  (count),
    .rd_idx (pos_m1[IDX_W-1:0]),
    .stat   (stat)
  );

  always_comb begin
    ctrl.op      = OP_HOLD;
    ctrl.value   = req.value;
    ctrl.pos_idx = pos_m1[IDX_W-1:0];
    count_next   = count;
    ok_next      = 1'b0;
    rd_next      = '0;
    fp_next      = '0;
    case (req.action)
      ACT_INSERT: begin
        if (count < CNT_W'(CAPACITY)) begin
          ctrl.op    = OP_INSERT;
          count_next = count + CNT_W'(1);
          ok_next    = 1'b1;
        end
      end
      ACT_REMOVE_VALUE: begin
        if (stat.found) begin
          ctrl.op    = OP_DEL_VALUE;
          count_next = count - CNT_W'(1);
          ok_next    = 1'b1;
        end
      end
      ACT_REMOVE_POS: begin
        if (pos_ok) begin
          ctrl.op    = OP_DEL_POS;
          count_next = count - CNT_W'(1);
          ok_next    = 1'b1;
        end
      end
      ACT_READ: begin
        if (pos_ok) begin
          rd_next = stat.rd_val;
          ok_next = 1'b1;
        end
      end
      ACT_FIND: begin
        if (stat.found) begin
          fp_next = fp_sum[POS_W-1:0];
          ok_next = 1'b1;
        end
      end
      ACT_CLEAR: begin
        count_next = '0;
        ok_next    = 1'b1;
      end
      default: ok_next = 1'b0;
    endcase
    if (!accept) begin
      ctrl.op    = OP_HOLD;
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.ok             <= ok_next;
      rsp.entry_value    <= rd_next;
      rsp.found_position <= fp_next;
      rsp.entry_count    <= ECNT_W'(count_next);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    accept && (req.action == ACT_CLEAR)
    |=> rsp.valid && rsp.ok && (rsp.entry_count == '0))
    else $error("clear did not empty the list");

  a_full_refused: assert property (@(posedge clk) disable iff (rst)
    accept && (req.action == ACT_INSERT) && (count == CNT_W'(CAPACITY))
    |=> !rsp.ok && (count == CNT_W'(CAPACITY)))
    else $error("insert into full list not refused");

  a_count_match: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.entry_count == ECNT_W'(count)))
    else $error("reported count differs from stored count");

endmodule
`default_nettype wire
